FILE: hdl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and constants shared by the positional ordered list unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND    = 3'd0,
        ACT_INS_START = 3'd1,
        ACT_INS_POS   = 3'd2,
        ACT_DEL_START = 3'd3,
        ACT_DEL_END   = 3'd4,
        ACT_DEL_POS   = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t status;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/positional_ordered_list_unit.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_unit
// Bounded ordered list of signed 32-bit values with insert and delete at the
// start, the end or a 1-based position. The entries sit in a row of cells;
// on each transfer every cell in parallel holds, loads the new value or takes
// its neighbour's entry, so one request is taken per clock cycle unless a
// response is stalled; the result is in the output register the cycle after.
// Throughput is set by the shift of the cell row and the OR tree that picks
// out the removed entry. The list is empty out of reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list_unit #(
    parameter int LIST_DEPTH = pol_pkg::LIST_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire logic [pol_pkg::ACTION_W-1:0]        action,
    input  wire logic signed [pol_pkg::VALUE_W-1:0]  value,
    input  wire logic [pol_pkg::POS_W-1:0]           position,
    output logic                                     rsp_valid,
    input  wire logic                                rsp_stall,
    output logic [pol_pkg::STATUS_W-1:0]             status,
    output logic signed [pol_pkg::VALUE_W-1:0]       removed_value,
    output logic [pol_pkg::COUNT_W-1:0]              count
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    logic                                go;
    pol_pkg::cmd_t                       cmd;
    logic [IDX_W-1:0]                    idx;
    logic [CNT_W-1:0]                    cnt;
    logic [CNT_W-1:0]                    cnt_after;
    logic signed [pol_pkg::VALUE_W-1:0]  cell_data [LIST_DEPTH];
    logic signed [pol_pkg::VALUE_W-1:0]  cell_sel  [LIST_DEPTH];
    logic signed [pol_pkg::VALUE_W-1:0]  picked;

    logic                                rsp_valid_reg;
    logic [pol_pkg::STATUS_W-1:0]        status_reg;
    logic signed [pol_pkg::VALUE_W-1:0]  removed_reg;
    logic [pol_pkg::COUNT_W-1:0]         count_reg;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign go        = req_valid && !req_stall;

    pol_ctrl #(
        .LIST_DEPTH (LIST_DEPTH),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .action    (action),
        .position  (position),
        .cmd       (cmd),
        .idx       (idx),
        .cnt       (cnt),
        .cnt_after (cnt_after)
    );

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        pol_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk        (clk),
            .op         (cmd.op),
            .idx        (idx),
            .value      (value),
            .left_data  ((i == 0) ? value : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data (cell_data[(i == LIST_DEPTH - 1) ? i : i + 1]),
            .data       (cell_data[i]),
            .sel_data   (cell_sel[i])
        );
    end

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            picked = picked | cell_sel[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (go)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            status_reg  <= cmd.status;
            removed_reg <= (cmd.op == pol_pkg::OP_DELETE) ? picked : '0;
            count_reg   <= pol_pkg::COUNT_W'(cnt_after);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count         = count_reg;

    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(cnt))
        else $error("entry count moved without a transfer");

    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        go && cmd.status != pol_pkg::ST_OK |=> $stable(cnt))
        else $error("rejected request changed the entry count");

    a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == pol_pkg::OP_INSERT |=> cnt == CNT_W'($past(cnt) + 1'b1))
        else $error("insert did not grow the list by one");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != pol_pkg::ST_OK |-> removed_value == '0)
        else $error("removed value set on a failed request");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

endmodule

`default_nettype wire

FILE: hdl/pol_cell.sv
// ----------------------------------------------------------------------------
// pol_cell
// One list slot: holds, loads the new value, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pol_cell #(
    parameter int IDX_W    = 4,
    parameter int CELL_IDX = 0
) (
    input  wire logic                                clk,
    input  wire pol_pkg::op_t                        op,
    input  wire logic [IDX_W-1:0]                    idx,
    input  wire logic signed [pol_pkg::VALUE_W-1:0]  value,
    input  wire logic signed [pol_pkg::VALUE_W-1:0]  left_data,
    input  wire logic signed [pol_pkg::VALUE_W-1:0]  right_data,
    output logic signed [pol_pkg::VALUE_W-1:0]       data,
    output logic signed [pol_pkg::VALUE_W-1:0]       sel_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic signed [pol_pkg::VALUE_W-1:0] data_reg;
    logic signed [pol_pkg::VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op)
            pol_pkg::OP_INSERT:
            begin
                if (MY_IDX == idx)
                begin
                    data_next = value;
                end
                else if (MY_IDX > idx)
                begin
                    data_next = left_data;
                end
            end
            pol_pkg::OP_DELETE:
            begin
                if (MY_IDX >= idx)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (MY_IDX == idx) ? data_reg : '0;

endmodule

`default_nettype wire

FILE: hdl/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl
// Request decode, bounds checks and entry count register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pol_ctrl #(
    parameter int LIST_DEPTH = pol_pkg::LIST_DEPTH_DEF,
    parameter int IDX_W      = $clog2(LIST_DEPTH),
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          go,
    input  wire logic [pol_pkg::ACTION_W-1:0]  action,
    input  wire logic [pol_pkg::POS_W-1:0]     position,
    output pol_pkg::cmd_t                      cmd,
    output logic [IDX_W-1:0]                   idx,
    output logic [CNT_W-1:0]                   cnt,
    output logic [CNT_W-1:0]                   cnt_after
);

    localparam int CMP_W = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CMP_W-1:0] cnt_w;
    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] idx_w;
    logic             full;
    logic             empty;
    pol_pkg::cmd_t    dec;

    assign cnt_w = CMP_W'(cnt_reg);
    assign pos_w = CMP_W'(position);
    assign full  = (cnt_reg == CNT_W'(LIST_DEPTH));
    assign empty = (cnt_reg == '0);

    always_comb
    begin
        dec.op     = pol_pkg::OP_HOLD;
        dec.status = pol_pkg::ST_OK;
        idx_w      = '0;
        case (action)
            pol_pkg::ACT_APPEND,
            pol_pkg::ACT_INS_START,
            pol_pkg::ACT_INS_POS:
            begin
                if (full)
                begin
                    dec.status = pol_pkg::ST_FULL;
                end
                else if (action == pol_pkg::ACT_APPEND)
                begin
                    dec.op = pol_pkg::OP_INSERT;
                    idx_w  = cnt_w;
                end
                else if (action == pol_pkg::ACT_INS_START)
                begin
                    dec.op = pol_pkg::OP_INSERT;
                end
                else if (pos_w == '0 || pos_w > cnt_w + 1'b1)
                begin
                    dec.status = pol_pkg::ST_INVALID;
                end
                else
                begin
                    dec.op = pol_pkg::OP_INSERT;
                    idx_w  = pos_w - 1'b1;
                end
            end
            pol_pkg::ACT_DEL_START,
            pol_pkg::ACT_DEL_END,
            pol_pkg::ACT_DEL_POS:
            begin
                if (empty)
                begin
                    dec.status = pol_pkg::ST_EMPTY;
                end
                else if (action == pol_pkg::ACT_DEL_START)
                begin
                    dec.op = pol_pkg::OP_DELETE;
                end
                else if (action == pol_pkg::ACT_DEL_END)
                begin
                    dec.op = pol_pkg::OP_DELETE;
                    idx_w  = cnt_w - 1'b1;
                end
                else if (pos_w == '0 || pos_w > cnt_w)
                begin
                    dec.status = pol_pkg::ST_INVALID;
                end
                else
                begin
                    dec.op = pol_pkg::OP_DELETE;
                    idx_w  = pos_w - 1'b1;
                end
            end
            default:
            begin
                dec.status = pol_pkg::ST_INVALID;
            end
        endcase
    end

    always_comb
    begin
        case (dec.op)
            pol_pkg::OP_INSERT: cnt_next = cnt_reg + 1'b1;
            pol_pkg::OP_DELETE: cnt_next = cnt_reg - 1'b1;
            default:            cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (go)
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cmd.op     = go ? dec.op : pol_pkg::OP_HOLD;
    assign cmd.status = dec.status;
    assign idx        = idx_w[IDX_W-1:0];
    assign cnt        = cnt_reg;
    assign cnt_after  = cnt_next;

endmodule

`default_nettype wire
